// File: sv/tdpm_pkg.sv
// Shared constants, request and register codes, and the control/status
// structs that pass between the rank mapper's controller and its datapath.
// No dependencies.
package tdpm_pkg;

  localparam int MAX_BASE   = 16;
  localparam int MAX_DIGITS = 8;

  localparam int RANK_W = 32;                  // rank and image width
  localparam int VAL_W  = $clog2(MAX_BASE);    // digit value width
  localparam int POS_W  = $clog2(MAX_DIGITS);  // digit position width
  localparam int IDX_W  = 4;                   // entry_index / entry_value width
  localparam int BASE_W = 5;                   // base register width
  localparam int CNT_W  = 4;                   // digit_count register width
  localparam int ACT_W  = 3;                   // active_component register width
  localparam int REQ_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Restoring divider: quotient bits produced per cycle, division steps per digit
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = RANK_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [BASE_W-1:0] BASE_RESET   = BASE_W'(2);
  localparam logic [CNT_W-1:0]  DIGITS_RESET = CNT_W'(1);

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_VALUE = 2'd0,
    REQ_LOAD_POS   = 2'd1,
    REQ_MAP        = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE   = 2'd0,
    CFG_DIGITS = 2'd1,
    CFG_ACTIVE = 2'd2,
    CFG_ALL    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic             load_value;
    logic             load_pos;
    logic             start;
    logic             div_step;
    logic             place;
    logic [POS_W-1:0] digit_idx;
    logic             comp_step;
    logic [POS_W-1:0] comp_idx;
    logic             emit;
    logic             emit_err;
  } tdpm_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] digits;     // saturated digit count
    logic             rank_over;  // rank not below base^digits
  } tdpm_status_t;

endpackage

// File: sv/tdpm_datapath.sv
// Datapath of the rank mapper: configuration registers, value and position
// tables, digit divider, placed-digit registers, recomposition and output.
// Depends on tdpm_pkg.
module tdpm_datapath import tdpm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [IDX_W-1:0]      entry_index_i,
  input  logic [IDX_W-1:0]      entry_value_i,
  input  logic [RANK_W-1:0]     source_rank_i,
  input  tdpm_cmd_t             cmd_i,
  output tdpm_status_t          status_o,
  output logic [RANK_W-1:0]     image_rank_o,
  output logic                  rank_error_o
);

  logic [BASE_W-1:0] base_q;
  logic [CNT_W-1:0]  digits_q;
  logic [ACT_W-1:0]  active_q;
  logic              all_q;

  logic [VAL_W-1:0] value_map_q [MAX_BASE];
  logic [POS_W-1:0] pos_map_q   [MAX_DIGITS];
  logic [VAL_W-1:0] placed_q    [MAX_DIGITS];

  logic [RANK_W-1:0] div_q, div_d;
  logic [VAL_W-1:0]  rem_q, rem_d;
  logic [RANK_W-1:0] acc_q;
  logic [RANK_W-1:0] image_q;
  logic              error_q;

  logic [BASE_W-1:0]   n_eff;
  logic [CNT_W-1:0]    m_eff;
  logic [VAL_W-1:0]    mapped;
  logic [POS_W-1:0]    pos;
  logic [RANK_W+BASE_W-1:0] prod;
  logic [VAL_W:0]      trial;

  assign n_eff = (base_q > BASE_W'(MAX_BASE)) ? BASE_W'(MAX_BASE) : base_q;
  assign m_eff = (digits_q > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : digits_q;

  assign status_o.digits    = m_eff;
  assign status_o.rank_over = (n_eff == '0) || (div_q != '0);

  // Restoring division of the remaining rank by the radix, DIV_BITS per cycle
  always_comb begin
    rem_d = rem_q;
    div_d = div_q;
    trial = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial = {rem_d, div_d[RANK_W-1]};
      div_d = {div_d[RANK_W-2:0], 1'b0};
      if (trial >= n_eff) begin
        trial    = trial - n_eff;
        div_d[0] = 1'b1;
      end
      rem_d = trial[VAL_W-1:0];
    end
  end

  assign mapped = (all_q || (cmd_i.digit_idx == active_q)) ? value_map_q[rem_q] : rem_q;
  assign pos    = pos_map_q[cmd_i.digit_idx];
  assign prod   = acc_q * n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= BASE_RESET;
      digits_q <= DIGITS_RESET;
      active_q <= '0;
      all_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_BASE:   base_q   <= cfg_data_i[BASE_W-1:0];
        CFG_DIGITS: digits_q <= cfg_data_i[CNT_W-1:0];
        CFG_ACTIVE: active_q <= cfg_data_i[ACT_W-1:0];
        CFG_ALL:    all_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_value) begin
      value_map_q[entry_index_i] <= entry_value_i;
    end
    if (cmd_i.load_pos && (entry_index_i[IDX_W-1:POS_W] == '0)) begin
      pos_map_q[entry_index_i[POS_W-1:0]] <= entry_value_i[POS_W-1:0];
    end

    if (cmd_i.start) begin
      div_q <= source_rank_i;
      rem_q <= '0;
      acc_q <= '0;
      for (int j = 0; j < MAX_DIGITS; j++) begin
        placed_q[j] <= '0;
      end
    end else begin
      if (cmd_i.div_step) begin
        div_q <= div_d;
        rem_q <= rem_d;
      end
      if (cmd_i.place) begin
        rem_q <= '0;
        if ({1'b0, pos} < m_eff) begin
          placed_q[pos] <= mapped;
        end
      end
      if (cmd_i.comp_step) begin
        acc_q <= prod[RANK_W-1:0] + RANK_W'(placed_q[cmd_i.comp_idx]);
      end
    end

    if (cmd_i.emit) begin
      image_q <= cmd_i.emit_err ? '0 : acc_q;
      error_q <= cmd_i.emit_err;
    end
  end

  assign image_rank_o = image_q;
  assign rank_error_o = error_q;

endmodule

// File: sv/tdpm_ctrl.sv
// Controller of the rank mapper: sequences digit division, placement,
// range check, recomposition and the output handshake.
// Depends on tdpm_pkg.
module tdpm_ctrl import tdpm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [REQ_W-1:0] req_type_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  tdpm_status_t     status_i,
  output tdpm_cmd_t        cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_PLACE,
    S_CHECK,
    S_COMPOSE,
    S_EMIT
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  cnt_m1;
  logic              err_q;
  logic              out_valid_q;
  logic              accept;
  logic              emit_ok;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign emit_ok     = !out_valid_q || !out_stall_i;
  assign cnt_m1      = cnt_q - CNT_W'(1);

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_e'(req_type_i))
            REQ_LOAD_VALUE: cmd_o.load_value = 1'b1;
            REQ_LOAD_POS:   cmd_o.load_pos   = 1'b1;
            REQ_MAP:        cmd_o.start      = 1'b1;
            default: ;
          endcase
        end
      end
      S_DIV: cmd_o.div_step = 1'b1;
      S_PLACE: begin
        cmd_o.place     = 1'b1;
        cmd_o.digit_idx = cnt_q[POS_W-1:0];
      end
      S_COMPOSE: begin
        cmd_o.comp_step = (cnt_q != '0);
        cmd_o.comp_idx  = cnt_m1[POS_W-1:0];
      end
      S_EMIT: begin
        cmd_o.emit     = emit_ok;
        cmd_o.emit_err = err_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_EMIT) && emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_o.start) begin
            cnt_q   <= '0;
            step_q  <= '0;
            state_q <= (status_i.digits == '0) ? S_CHECK : S_DIV;
          end
        end
        S_DIV: begin
          if (step_q == STEP_W'(DIV_STEPS - 1)) begin
            step_q  <= '0;
            state_q <= S_PLACE;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        S_PLACE: begin
          if ((cnt_q + CNT_W'(1)) == status_i.digits) begin
            state_q <= S_CHECK;
          end else begin
            cnt_q   <= cnt_q + CNT_W'(1);
            state_q <= S_DIV;
          end
        end
        S_CHECK: begin
          if (status_i.rank_over) begin
            err_q   <= 1'b1;
            state_q <= S_EMIT;
          end else begin
            err_q   <= 1'b0;
            cnt_q   <= status_i.digits;
            state_q <= S_COMPOSE;
          end
        end
        S_COMPOSE: begin
          if (cnt_q == '0) begin
            state_q <= S_EMIT;
          end else begin
            cnt_q <= cnt_m1;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/tuple_digit_permutation_mapper.sv
// Top level of the tuple digit permutation mapper: joins the controller
// and the datapath. Depends on tdpm_pkg, tdpm_ctrl and tdpm_datapath.
//
// Usage
//   Input channel (in_valid_i / in_stall_o) carries one transaction per item:
//   req_type 0 loads a value map entry, 1 loads a position map entry, 2 maps
//   source_rank; code 3 is dropped. Loads and dropped codes give no result
//   and do not stall the input. A map transaction splits the rank into
//   digit_count base-n digits, permutes their positions, maps the values of
//   the active digit (or of all digits) and returns image_rank and rank_error
//   on the output channel (out_valid_o / out_stall_i). A map transaction
//   holds the input stalled until its result is emitted. The radix divider
//   yields four quotient bits a cycle to split off each digit, which is then
//   placed; after a range check, recomposition takes one multiply-add per
//   digit, and an out-of-range rank skips it.
//   The result sits in an output register, so the next transaction is taken
//   while a result waits; a further map result waits in the final state
//   until the receiver drops stall, and the input stays stalled meanwhile.
//   Reset clears the configuration to base 2, one digit, component 0, single
//   mode, and empties the output; the maps hold nothing until loaded. The
//   user makes cfg_we_i configuration writes only while idle (not enforced).
module tuple_digit_permutation_mapper import tdpm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [REQ_W-1:0]      req_type_i,
  input  logic [IDX_W-1:0]      entry_index_i,
  input  logic [IDX_W-1:0]      entry_value_i,
  input  logic [RANK_W-1:0]     source_rank_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [RANK_W-1:0]     image_rank_o,
  output logic                  rank_error_o
);

  tdpm_cmd_t    cmd;
  tdpm_status_t status;

  // Sequence the digit loop and own both handshakes
  tdpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold tables and configuration, divide, place and recompose
  tdpm_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .source_rank_i (source_rank_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .image_rank_o  (image_rank_o),
    .rank_error_o  (rank_error_o)
  );

endmodule

// File: sv/tdpm_checker.sv
// Port-level checks for the tuple digit permutation mapper, bound to the
// top level. Depends on tdpm_pkg.
module tdpm_checker import tdpm_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [REQ_W-1:0]      req_type_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [RANK_W-1:0]     image_rank_o,
  input logic                  rank_error_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(image_rank_o)
      && $stable(rank_error_o))
    else $error("stalled result changed");

  // An out-of-range rank reports image zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rank_error_o |-> image_rank_o == '0)
    else $error("error result with nonzero image");

  // A map transaction occupies the block
  a_map_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == REQ_MAP) |=> in_stall_o)
    else $error("map transaction did not stall the input");

  // Loads and dropped codes finish in the cycle they are taken
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i != REQ_MAP) |=> !in_stall_o)
    else $error("load transaction stalled the input");

  // A new result only appears at the end of a map
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a map in progress");

endmodule

bind tuple_digit_permutation_mapper tdpm_checker u_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for tuple_digit_permutation_mapper: table loads and rank
// maps under random idling on both channels, each image checked against a
// behavioural predictor held here. Depends on tdpm_pkg and the mapper RTL.
module testbench;
  import tdpm_pkg::*;

  localparam int CLK_HALF_NS     = 2;
  localparam int RESET_CYCLES    = 11;
  // Room for twice the longest map before touching registers
  localparam int SETTLE_CYCLES   = 2 * (10 * MAX_DIGITS + 3);
  localparam int LIMIT_CYCLES    = 1_000_000;
  localparam int PHASES          = 12;
  localparam int FIXED_SETTINGS  = 9;
  localparam int ITEMS_PER_PHASE = 85;
  localparam int DIRECTED_N      = 17;
  localparam int SENDER          = 0;
  localparam int RECEIVER        = 1;

  // Request code that the block drops without a result
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam longint unsigned RANK_SPAN_CAP = 64'h1_0000_0000;

  typedef struct packed {
    logic [RANK_W-1:0] image;
    logic              err;
  } image_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  val;
    logic [RANK_W-1:0] rank;
    logic              typed;   // result below is written out by hand
    image_t            result;
  } stim_row_t;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [CNT_W-1:0]  digits;
    logic [ACT_W-1:0]  active;
    logic              all;
  } setting_t;

  // ---------------------------------------------------------------------------
  // Block ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = CFG_BASE;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic [REQ_W-1:0]      req_type_i    = REQ_LOAD_VALUE;
  logic [IDX_W-1:0]      entry_index_i = '0;
  logic [IDX_W-1:0]      entry_value_i = '0;
  logic [RANK_W-1:0]     source_rank_i = '0;
  logic                  out_stall_i   = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [RANK_W-1:0]     image_rank_o;
  logic                  rank_error_o;

  tuple_digit_permutation_mapper dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .source_rank_i (source_rank_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .image_rank_o  (image_rank_o),
    .rank_error_o  (rank_error_o)
  );

  always begin
    #CLK_HALF_NS clk_i = 1'b1;
    #CLK_HALF_NS clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the registers and both tables
  // ---------------------------------------------------------------------------
  logic [BASE_W-1:0] model_base   = BASE_RESET;
  logic [CNT_W-1:0]  model_digits = DIGITS_RESET;
  logic [ACT_W-1:0]  model_active = '0;
  logic              model_all    = 1'b0;
  logic [VAL_W-1:0]  value_tbl [MAX_BASE];
  logic [POS_W-1:0]  pos_tbl   [MAX_DIGITS];

  image_t pending_images [$];   // images still owed by the block, oldest first

  int fail_count      = 0;
  int map_count       = 0;
  int range_err_count = 0;
  int load_count      = 0;
  int setting_count   = 0;
  int cycle_count     = 0;
  int recv_hold       = 0;
  bit calm_mode [2]   = '{1'b0, 1'b0};

  // Directed rows, all at the reset setting (base 2, one digit, component 0,
  // single mode). In-range maps come only after their tables are loaded.
  stim_row_t directed_rows [DIRECTED_N] = '{
    // rank at the radix and the top rank: out of range, flagged
    '{REQ_MAP,        4'h0, 4'h0, 32'd2,          1'b1, '{32'd0, 1'b1}},
    '{REQ_MAP,        4'hF, 4'hF, 32'hFFFF_FFFF,  1'b1, '{32'd0, 1'b1}},
    // position load keeps only its low three bits: stores 0
    '{REQ_LOAD_POS,   4'h0, 4'h8, 32'd0,          1'b0, '0},
    '{REQ_LOAD_VALUE, 4'h0, 4'h1, 32'd0,          1'b0, '0},
    '{REQ_LOAD_VALUE, 4'h1, 4'h0, 32'd0,          1'b0, '0},
    // value map swaps 0 and 1 on the single digit
    '{REQ_MAP,        4'h0, 4'h0, 32'd0,          1'b1, '{32'd1, 1'b0}},
    '{REQ_MAP,        4'h0, 4'h0, 32'd1,          1'b1, '{32'd0, 1'b0}},
    // unused code and position loads past the table: dropped
    '{REQ_UNUSED,     4'hF, 4'hF, 32'hFFFF_FFFF,  1'b0, '0},
    '{REQ_LOAD_POS,   4'hF, 4'h7, 32'd0,          1'b0, '0},
    '{REQ_LOAD_POS,   4'h8, 4'h3, 32'd0,          1'b0, '0},
    '{REQ_LOAD_VALUE, 4'hF, 4'hF, 32'd0,          1'b0, '0},
    // image well above the radix is recomposed as stored
    '{REQ_LOAD_VALUE, 4'h1, 4'hF, 32'd0,          1'b0, '0},
    '{REQ_MAP,        4'h0, 4'h0, 32'd1,          1'b0, '0},
    // digit sent past the digit count is lost
    '{REQ_LOAD_POS,   4'h0, 4'h7, 32'd0,          1'b0, '0},
    '{REQ_MAP,        4'h0, 4'h0, 32'd1,          1'b0, '0},
    '{REQ_LOAD_POS,   4'h0, 4'h0, 32'd0,          1'b0, '0},
    '{REQ_MAP,        4'h0, 4'h0, 32'd0,          1'b0, '0}
  };

  // Register settings for the first phases: the largest legal setting in
  // both modes, saturation of base and digit count, base zero, no digits,
  // base one, a component beyond the digit count, the smallest radix at
  // full width, and one middle case. Later phases draw at random.
  setting_t fixed_settings [FIXED_SETTINGS] = '{
    '{5'd16, 4'd8,  3'd3, 1'b1},
    '{5'd16, 4'd8,  3'd7, 1'b0},
    '{5'd31, 4'd15, 3'd5, 1'b1},
    '{5'd0,  4'd3,  3'd0, 1'b1},
    '{5'd5,  4'd0,  3'd0, 1'b1},
    '{5'd1,  4'd4,  3'd2, 1'b0},
    '{5'd3,  4'd5,  3'd7, 1'b0},
    '{5'd2,  4'd8,  3'd0, 1'b0},
    '{5'd10, 4'd6,  3'd4, 1'b1}
  };

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int sat_radix();
    return (model_base > MAX_BASE) ? MAX_BASE : int'(model_base);
  endfunction

  function automatic int sat_digits();
    return (model_digits > MAX_DIGITS) ? MAX_DIGITS : int'(model_digits);
  endfunction

  // Radix to the digit count, held at 2^32 since no rank can reach it
  function automatic longint unsigned rank_span();
    longint unsigned span;
    int n;
    int m;
    span = 1;
    n = sat_radix();
    m = sat_digits();
    for (int i = 0; i < m; i++) begin
      span = span * n;
      if (span >= RANK_SPAN_CAP) return RANK_SPAN_CAP;
    end
    return span;
  endfunction

  // Split into digits, move each, map its value where asked, recompose
  function automatic image_t map_rank_image(input logic [RANK_W-1:0] rank);
    image_t          res;
    int              n;
    int              m;
    int              d;
    int              p;
    longint unsigned rest;
    longint unsigned acc;
    logic [VAL_W-1:0] placed [MAX_DIGITS];
    n = sat_radix();
    m = sat_digits();
    res.image = '0;
    res.err   = 1'b1;
    if (n == 0 || rank >= rank_span()) return res;
    foreach (placed[k]) placed[k] = '0;
    rest = rank;
    for (int i = 0; i < m; i++) begin
      d    = int'(rest % n);
      rest = rest / n;
      if (model_all || i == model_active) d = int'(value_tbl[d]);
      p = int'(pos_tbl[i]);
      // positions nobody writes stay 0; on a collision the later digit wins
      if (p < m) placed[p] = VAL_W'(d);
    end
    acc = 0;
    for (int i = 0; i < m; i++)
      acc = (acc * n + placed[m - 1 - i]) & (RANK_SPAN_CAP - 1);
    res.image = acc[RANK_W-1:0];
    res.err   = 1'b0;
    return res;
  endfunction

  // Apply one accepted transaction to the predictor
  task automatic record_accept(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                               input logic [IDX_W-1:0] val, input logic [RANK_W-1:0] rank,
                               input bit typed, input image_t typed_res);
    image_t res;
    case (req)
      REQ_LOAD_VALUE: begin
        if (idx < MAX_BASE) value_tbl[idx] = val;
        load_count++;
      end
      REQ_LOAD_POS: begin
        if (idx < MAX_DIGITS) pos_tbl[idx[POS_W-1:0]] = val[POS_W-1:0];
        load_count++;
      end
      REQ_MAP: begin
        res = typed ? typed_res : map_rank_image(rank);
        pending_images.push_back(res);
        map_count++;
        if (res.err) range_err_count++;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Idling: a random gap per transaction, with calm stretches of none
  // ---------------------------------------------------------------------------
  function automatic int idle_draw(input int side);
    if ($urandom_range(0, 39) == 0) calm_mode[side] = !calm_mode[side];
    return calm_mode[side] ? 0 : int'($urandom_range(0, 3));
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side; every task starts and ends at a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                              input logic [IDX_W-1:0] val, input logic [RANK_W-1:0] rank,
                              input bit typed, input image_t typed_res);
    int gap;
    gap = idle_draw(SENDER);
    // Drop valid only when a gap is wanted, so it is never lowered and
    // raised within one step
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    entry_index_i <= idx;
    entry_value_i <= val;
    source_rank_i <= rank;
    // Hold the payload until the block takes it
    do @(posedge clk_i); while (in_stall_o);
    record_accept(req, idx, val, rank, typed, typed_res);
  endtask

  // Pause the sender until every owed image has come back
  task automatic drain_images();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_images.size() != 0) @(posedge clk_i);
  endtask

  // Loads give no result, so let the block finish any in flight as well
  task automatic settle_block();
    drain_images();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e which, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (which)
      CFG_BASE:   model_base   = data[BASE_W-1:0];
      CFG_DIGITS: model_digits = data[CNT_W-1:0];
      CFG_ACTIVE: model_active = data[ACT_W-1:0];
      CFG_ALL:    model_all    = data[0];
      default: ;
    endcase
  endtask

  // Write all four registers; spare data bits carry noise the block must mask
  task automatic apply_setting(input setting_t s);
    write_reg(CFG_BASE,   s.base);
    write_reg(CFG_DIGITS, {1'($urandom), s.digits});
    write_reg(CFG_ACTIVE, {2'($urandom), s.active});
    write_reg(CFG_ALL,    {4'($urandom), s.all});
    cfg_we_i <= 1'b0;
    setting_count++;
  endtask

  function automatic void shuffle(output int perm [MAX_BASE], input int k);
    int j;
    int t;
    for (int i = 0; i < MAX_BASE; i++) perm[i] = i;
    for (int i = k - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
  endfunction

  // Load every entry of both tables so no map ever reads an unwritten one;
  // half the time the live part is a true permutation
  task automatic fill_tables();
    int  perm [MAX_BASE];
    int  n;
    int  m;
    bit  as_perm;
    logic [IDX_W-1:0] v;
    n = sat_radix();
    m = sat_digits();
    as_perm = $urandom_range(0, 1);
    shuffle(perm, n);
    for (int i = 0; i < MAX_BASE; i++) begin
      v = (as_perm && i < n) ? IDX_W'(perm[i]) : IDX_W'($urandom);
      send_request(REQ_LOAD_VALUE, IDX_W'(i), v, $urandom, 1'b0, '0);
    end
    as_perm = $urandom_range(0, 1);
    shuffle(perm, m);
    for (int i = 0; i < MAX_DIGITS; i++) begin
      v = (as_perm && i < m) ? IDX_W'(perm[i]) : IDX_W'($urandom);
      send_request(REQ_LOAD_POS, IDX_W'(i), v, $urandom, 1'b0, '0);
    end
  endtask

  // Mostly ranks in range, with the top rank and out-of-range ones mixed in
  function automatic logic [RANK_W-1:0] pick_rank();
    longint unsigned span;
    longint unsigned r;
    int              roll;
    span = rank_span();
    r    = $urandom;
    roll = $urandom_range(0, 99);
    if (span == 0 || roll >= 90) return RANK_W'(r);
    if (roll < 70) return RANK_W'(r % span);
    if (roll < 80) return RANK_W'(span - 1);
    if (span == RANK_SPAN_CAP) return RANK_W'(r);
    return RANK_W'(span + r % (RANK_SPAN_CAP - span));
  endfunction

  // Random mix; dropped requests and pauses do not count toward the total
  task automatic random_items(input int count);
    int done;
    int roll;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        drain_images();
      end else if (roll < 60) begin
        send_request(REQ_MAP, IDX_W'($urandom), IDX_W'($urandom), pick_rank(), 1'b0, '0);
        done++;
      end else if (roll < 72) begin
        send_request(REQ_LOAD_VALUE, IDX_W'($urandom), IDX_W'($urandom), $urandom, 1'b0, '0);
        done++;
      end else if (roll < 84) begin
        send_request(REQ_LOAD_POS, IDX_W'($urandom_range(0, MAX_DIGITS - 1)),
                     IDX_W'($urandom), $urandom, 1'b0, '0);
        done++;
      end else if (roll < 91) begin
        send_request(REQ_LOAD_POS, IDX_W'($urandom_range(MAX_DIGITS, 15)),
                     IDX_W'($urandom), $urandom, 1'b0, '0);
      end else begin
        send_request(REQ_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom, 1'b0, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: check each accepted image, then hold stall for a drawn count
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : image_check
    image_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_images.size() == 0) begin
        $error("image_rank: no transaction owed, got %h (rank_error %b)",
               image_rank_o, rank_error_o);
        fail_count++;
      end else begin
        want = pending_images.pop_front();
        if (image_rank_o !== want.image) begin
          $error("image_rank: expected %h, actual %h", want.image, image_rank_o);
          fail_count++;
        end
        if (rank_error_o !== want.err) begin
          $error("rank_error: expected %b, actual %b", want.err, rank_error_o);
          fail_count++;
        end
      end
      recv_hold = idle_draw(RECEIVER);
    end
    if (recv_hold != 0) begin
      out_stall_i <= 1'b1;
      recv_hold--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Run: reset, directed rows, then phases of settings with random traffic
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    setting_t s;
    int       p;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r])
      send_request(directed_rows[r].req, directed_rows[r].idx, directed_rows[r].val,
                   directed_rows[r].rank, directed_rows[r].typed, directed_rows[r].result);

    for (p = 0; p < PHASES; p++) begin
      // registers change only with the block idle
      settle_block();
      if (p < FIXED_SETTINGS) begin
        s = fixed_settings[p];
      end else begin
        s.base   = BASE_W'($urandom_range(1, MAX_BASE));
        s.digits = CNT_W'($urandom_range(1, MAX_DIGITS));
        s.active = ACT_W'($urandom);
        s.all    = 1'($urandom);
      end
      apply_setting(s);
      fill_tables();
      random_items(ITEMS_PER_PHASE);
    end

    settle_block();
    $display("covered %0d rank maps (%0d out of range) and %0d table loads",
             map_count, range_err_count, load_count);
    $display("across %0d register settings with random idling on both channels",
             setting_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
